### hdl/adaptive_morse_decoder_macros.svh
// assertion macros, sampled on clk and disabled during reset
`ifndef ADAPTIVE_MORSE_DECODER_MACROS_SVH
`define ADAPTIVE_MORSE_DECODER_MACROS_SVH

// same-cycle implication
`define AMD_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/amd_pkg.sv
`timescale 1ns / 1ps
package amd_pkg;

  localparam int TICK_W      = 16;
  localparam int DASH_W      = 18;
  localparam int CHAR_W      = 7;
  localparam int NUM_LETTERS = 26;
  localparam int MAX_LOOKUP  = 4;

  localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

  localparam logic [CHAR_W-1:0] CHAR_A       = 7'd65;
  localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'd63;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'd32;

  localparam logic CFG_MIN_DOT = 1'b0;
  localparam logic CFG_MAX_DOT = 1'b1;

  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  localparam logic [2:0] LETTER_LEN [NUM_LETTERS] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };
  localparam logic [3:0] LETTER_BITS [NUM_LETTERS] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
    4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };

  typedef struct packed {
    logic level;
  } amd_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last;
  } amd_out_t;

  typedef struct packed {
    logic fire;
    logic level;
  } amd_tick_t;

  typedef struct packed {
    logic [1:0] n;
    amd_out_t   res0;
    amd_out_t   res1;
  } amd_push_t;

  function automatic logic [CHAR_W-1:0] amd_lookup(input logic [2:0] len,
                                                   input logic [3:0] pat);
    logic [CHAR_W-1:0] code;
    code = CHAR_UNKNOWN;
    for (int i = NUM_LETTERS - 1; i >= 0; i--) begin
      if (LETTER_LEN[i] == len && LETTER_BITS[i] == pat) begin
        code = CHAR_A + CHAR_W'(i);
      end
    end
    return code;
  endfunction

endpackage

### hdl/amd_stream_if.sv
`timescale 1ns / 1ps
interface amd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/adaptive_morse_decoder.sv
`timescale 1ns / 1ps
// adaptive morse decoder
// in_ch carries one tone-detector level per 1 ms tick; out_ch carries decoded
// characters (A-Z, '?' for unknown, space for a word gap) with last set on the
// final character caused by one tick. a tick causes zero, one or two results.
// cfg_we/cfg_index/cfg_data write min_dot_ticks (index 0) and max_dot_ticks
// (index 1); write them only while the block is idle.
// throughput: one tick per cycle while the queue has room. a tick is held in
// the input register and, when the queue has room, is decoded into a
// four-entry result queue, so a result is visible on out_ch once it is written
// to the queue and can transfer from there.
// the input register advances only while the queue has room for two results;
// a stalled receiver fills the queue and then holds in_ch.ready low, and no
// result is lost. results leave at one per cycle while out_ch.ready is high.
// reset (rst_n low at a clock edge) empties the queue, clears the run counters
// and learned speed, and restores the dot limits to 30 and 120 ticks.
module adaptive_morse_decoder #(
  parameter int MAX_ELEMENTS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  amd_stream_if.sink                 in_ch,
  amd_stream_if.source               out_ch,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [amd_pkg::TICK_W-1:0] cfg_data
);
  import amd_pkg::*;

  amd_tick_t tick;
  amd_push_t push;
  logic      room;

  amd_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .room  (room),
    .tick  (tick)
  );

  amd_core #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick),
    .push      (push)
  );

  amd_out_fifo u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

### hdl/amd_in_stage.sv
`timescale 1ns / 1ps
module amd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  amd_stream_if.sink        in_ch,
  input  logic              room,
  output amd_pkg::amd_tick_t tick
);
  import amd_pkg::*;

  logic valid_r;
  logic valid_nxt;
  logic level_r;
  logic advance;

  assign advance     = valid_r && room;
  assign in_ch.ready = !valid_r || room;
  assign tick.fire   = advance;
  assign tick.level  = level_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ch.ready) begin
      valid_nxt = in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      level_r <= in_ch.data.level;
    end
  end

endmodule

### hdl/amd_core.sv
`timescale 1ns / 1ps
`include "adaptive_morse_decoder_macros.svh"
module amd_core #(
  parameter int MAX_ELEMENTS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [amd_pkg::TICK_W-1:0]      cfg_data,
  input  amd_pkg::amd_tick_t              tick,
  output amd_pkg::amd_push_t              push
);
  import amd_pkg::*;

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int IDX_W = $clog2(MAX_ELEMENTS);

  logic [TICK_W-1:0]       min_dot_r, max_dot_r;
  logic [MAX_ELEMENTS-1:0] store_r, store_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [TICK_W-1:0]       mark_r, mark_nxt;
  logic [TICK_W-1:0]       space_r, space_nxt;
  logic                    prev_r, prev_nxt;
  logic                    in_word_r, in_word_nxt;
  logic [TICK_W-1:0]       dot_r, dot_nxt;
  logic [DASH_W-1:0]       dash_r, dash_nxt;
  logic                    locked_r, locked_nxt;
  logic                    ovf_r, ovf_nxt;

  logic [TICK_W-1:0]   learn_dot;
  logic [DASH_W-1:0]   learn_dash;
  logic                lock_hit;
  logic [DASH_W-1:0]   dot3;
  logic [DASH_W:0]     dot7;
  logic                space_ge3, space_ge7;
  logic                has_letter;
  logic [3:0]          pat;
  logic [CHAR_W-1:0]   letter;

  // speed learning candidate
  always_comb begin
    learn_dot = dot_r;
    if (dot_r == '0) begin
      learn_dot = mark_r;
    end else if (mark_r >= min_dot_r && mark_r <= max_dot_r && mark_r < dot_r) begin
      learn_dot = mark_r;
    end
  end

  assign learn_dash = {2'b00, learn_dot} + {1'b0, learn_dot, 1'b0};
  assign lock_hit   = {1'b0, mark_r} >= {learn_dot, 1'b0};

  assign dot3      = {2'b00, dot_r} + {1'b0, dot_r, 1'b0};
  assign dot7      = {dot_r, 3'b000} - {3'b000, dot_r};
  assign space_ge3 = {2'b00, space_r} >= dot3;
  assign space_ge7 = {3'b000, space_r} >= dot7;

  // symbol lookup, only the held elements count
  always_comb begin
    for (int j = 0; j < MAX_LOOKUP; j++) begin
      pat[j] = store_r[j] && (CNT_W'(j) < cnt_r);
    end
  end

  assign has_letter = (cnt_r != '0) || ovf_r;

  always_comb begin
    if (ovf_r || cnt_r > CNT_W'(MAX_LOOKUP)) begin
      letter = CHAR_UNKNOWN;
    end else begin
      letter = amd_lookup(cnt_r[2:0], pat);
    end
  end

  always_comb begin
    store_nxt   = store_r;
    cnt_nxt     = cnt_r;
    mark_nxt    = mark_r;
    space_nxt   = space_r;
    prev_nxt    = prev_r;
    in_word_nxt = in_word_r;
    dot_nxt     = dot_r;
    dash_nxt    = dash_r;
    locked_nxt  = locked_r;
    ovf_nxt     = ovf_r;
    push        = '0;
    if (tick.fire) begin
      if (tick.level == prev_r) begin
        if (tick.level) begin
          if (mark_r != TICK_MAX) begin
            mark_nxt = mark_r + 16'd1;
          end
        end else begin
          if (space_r != TICK_MAX) begin
            space_nxt = space_r + 16'd1;
          end
        end
      end else if (prev_r) begin
        // end of mark
        if (dot_r != '0 && mark_r >= dot_r) begin
          if (cnt_r < CNT_W'(MAX_ELEMENTS)) begin
            store_nxt[cnt_r[IDX_W-1:0]] = {2'b00, mark_r} >= dash_r;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        if (!locked_r) begin
          dot_nxt  = learn_dot;
          dash_nxt = learn_dash;
          if (lock_hit) begin
            locked_nxt = 1'b1;
          end
        end
        mark_nxt    = '0;
        in_word_nxt = 1'b1;
      end else begin
        // end of space
        if (dot_r != '0 && in_word_r) begin
          if (space_ge7) begin
            if (has_letter) begin
              push.n    = 2'd2;
              push.res0 = '{char_code: letter, last: 1'b0};
              push.res1 = '{char_code: CHAR_SPACE, last: 1'b1};
            end else begin
              push.n    = 2'd1;
              push.res0 = '{char_code: CHAR_SPACE, last: 1'b1};
            end
            cnt_nxt     = '0;
            ovf_nxt     = 1'b0;
            in_word_nxt = 1'b0;
          end else if (space_ge3 && has_letter) begin
            push.n    = 2'd1;
            push.res0 = '{char_code: letter, last: 1'b1};
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
          end
        end
        space_nxt = '0;
      end
      prev_nxt = tick.level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dot_r <= 16'd30;
      max_dot_r <= 16'd120;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MIN_DOT) begin
        min_dot_r <= cfg_data;
      end
      if (cfg_index == CFG_MAX_DOT) begin
        max_dot_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      mark_r    <= '0;
      space_r   <= '0;
      prev_r    <= 1'b0;
      in_word_r <= 1'b0;
      dot_r     <= '0;
      dash_r    <= '0;
      locked_r  <= 1'b0;
      ovf_r     <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      mark_r    <= mark_nxt;
      space_r   <= space_nxt;
      prev_r    <= prev_nxt;
      in_word_r <= in_word_nxt;
      dot_r     <= dot_nxt;
      dash_r    <= dash_nxt;
      locked_r  <= locked_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    store_r <= store_nxt;
  end

  `AMD_ASSERT_NEXT(a_lock_sticky, locked_r, locked_r, "speed lock released")
  `AMD_ASSERT(a_ovf_full, ovf_r, cnt_r == CNT_W'(MAX_ELEMENTS), "overflow with free slots")
  `AMD_ASSERT(a_dash_len, 1'b1, dash_r == dot3, "dash length out of step with dot length")

endmodule

### hdl/amd_out_fifo.sv
`timescale 1ns / 1ps
`include "adaptive_morse_decoder_macros.svh"
module amd_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  amd_pkg::amd_push_t push,
  output logic               room,
  amd_stream_if.source       out_ch
);
  import amd_pkg::*;

  amd_out_t               mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OUT_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OUT_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                   pop;
  logic [OUT_PTR_W-1:0]   wr_ptr_inc;

  assign room         = cnt_r <= OUT_CNT_W'(OUT_DEPTH - 2);
  assign out_ch.valid = cnt_r != '0;
  assign out_ch.data  = mem_r[rd_ptr_r];
  assign pop          = out_ch.valid && out_ch.ready;
  assign wr_ptr_inc   = wr_ptr_r + OUT_PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + OUT_PTR_W'(push.n);
    rd_ptr_nxt = rd_ptr_r + OUT_PTR_W'(pop);
    cnt_nxt    = cnt_r + OUT_CNT_W'(push.n) - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.n == 2'd2) begin
      mem_r[wr_ptr_inc] <= push.res1;
    end
  end

  `AMD_ASSERT(a_push_room, push.n != 2'd0, room, "result transfer into full queue")
  `AMD_ASSERT(a_cnt_bound, 1'b1, cnt_r <= OUT_CNT_W'(OUT_DEPTH), "queue count past depth")

endmodule
